@@ design/eegfd_pkg.sv @@
// Package for the biosignal frame deframer: frame layout, widths,
// register indexes and register reset values.
// No dependencies.
package eegfd_pkg;

    // Widths of the stream, the samples and the scaled results
    localparam int POS_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 24;
    localparam int SCALE_W  = 24;
    localparam int UV_W     = 32;
    localparam int LOSS_W   = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_CHANNELS = 8;

    // Frame layout
    localparam logic [POS_W-1:0] SEQ_POS    = 6'd6;
    localparam int               SAMPLE_POS = 12;
    localparam int               UV_SHIFT   = 16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE      = 2'd0,
        CFG_DECIMATION = 2'd1,
        CFG_HEADER     = 2'd2
    } cfg_index_t;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET      = 24'd375000;
    localparam logic [BYTE_W-1:0]  DECIMATION_RESET = 8'd8;
    localparam logic [BYTE_W-1:0]  HEADER_RESET     = 8'hA0;

    localparam logic [LOSS_W-1:0]  LOSS_MAX = {LOSS_W{1'b1}};

endpackage

@@ design/eeg_frame_deframer.sv @@
// Top level of the biosignal frame deframer: byte framing, sequence check,
// decimation flag and scaling of the samples to microvolts.
// Depends on eegfd_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | rx_byte
//   output   | out_valid / out_ready| chan1_uv..chan8_uv, keep_for_plot,
//            |                      | seq_lost, loss_total
//   config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// One byte is taken in every cycle. The eight products are formed by eight
// parallel 24x25 multipliers in the cycle that takes a frame's last byte, and
// the frame's result is valid in the result register from the next cycle on.
// The input stalls only on a frame's last byte while the previous result
// still waits in the result register; every other byte passes.
// rst_n clears framing, counters and the result valid and loads the register
// defaults.
module eeg_frame_deframer #(
    parameter int FRAME_BYTES = 37,
    parameter int CHANNELS    = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [eegfd_pkg::BYTE_W-1:0]          rx_byte,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan1_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan2_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan3_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan4_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan5_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan6_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan7_uv,
    output logic signed [eegfd_pkg::UV_W-1:0]     chan8_uv,
    output logic                                  keep_for_plot,
    output logic                                  seq_lost,
    output logic [eegfd_pkg::LOSS_W-1:0]          loss_total,

    input  logic                                  cfg_we,
    input  logic [eegfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eegfd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int POS_W    = eegfd_pkg::POS_W;
    localparam int BYTE_W   = eegfd_pkg::BYTE_W;
    localparam int SAMPLE_W = eegfd_pkg::SAMPLE_W;
    localparam int SCALE_W  = eegfd_pkg::SCALE_W;
    localparam int UV_W     = eegfd_pkg::UV_W;
    localparam int LOSS_W   = eegfd_pkg::LOSS_W;
    localparam int PROD_W   = SAMPLE_W + SCALE_W + 1;
    localparam int OUT_CH   = eegfd_pkg::OUT_CHANNELS;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // Configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [BYTE_W-1:0]  decimation_reg;
    logic [BYTE_W-1:0]  header_reg;

    // Framing and sequence state
    logic                synced_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [BYTE_W-1:0]   seq_now_reg;
    logic [BYTE_W-1:0]   seq_prev_reg;
    logic                seen_first_reg;
    logic [LOSS_W-1:0]   loss_reg;
    logic [LOSS_W-1:0]   loss_next;
    logic [BYTE_W-1:0]   decim_reg;
    logic [BYTE_W-1:0]   decim_next;
    logic [SAMPLE_W-1:0] chan_raw_reg  [CHANNELS];
    logic [SAMPLE_W-1:0] chan_raw_next [CHANNELS];

    // Result register
    logic                   out_valid_reg;
    logic signed [UV_W-1:0] uv_reg [CHANNELS];
    logic                   keep_reg;
    logic                   lost_reg;
    logic [LOSS_W-1:0]      loss_out_reg;

    logic                   uv_next [CHANNELS];
    logic signed [UV_W-1:0] uv_val  [CHANNELS];
    logic signed [UV_W-1:0] uv_port [OUT_CH];

    logic              hdr_hit;
    logic              active;
    logic              last_byte;
    logic [POS_W-1:0]  pos_cur;
    logic              in_fire;
    logic              frame_done;
    logic              lost;
    logic              keep;
    logic [BYTE_W:0]   decim_inc;

    // Stall only a frame's last byte while the result register is still full
    assign last_byte  = synced_reg && (pos_reg == LAST_POS);
    assign in_ready   = !out_valid_reg || out_ready || !last_byte;
    assign in_fire    = in_valid && in_ready;
    assign frame_done = in_fire && last_byte;

    assign hdr_hit = !synced_reg && (rx_byte == header_reg);
    assign active  = synced_reg || hdr_hit;
    assign pos_cur = synced_reg ? pos_reg : '0;
    assign pos_next = last_byte ? '0 : pos_cur + POS_W'(1);

    // Shift each byte into the sample it belongs to
    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (active && ((pos_cur == POS_W'(eegfd_pkg::SAMPLE_POS + 3 * k))
                        || (pos_cur == POS_W'(eegfd_pkg::SAMPLE_POS + 3 * k + 1))
                        || (pos_cur == POS_W'(eegfd_pkg::SAMPLE_POS + 3 * k + 2))))
            begin
                chan_raw_next[k] = {chan_raw_reg[k][SAMPLE_W-BYTE_W-1:0], rx_byte};
                uv_next[k] = 1'b1;
            end
            else
            begin
                chan_raw_next[k] = chan_raw_reg[k];
                uv_next[k] = 1'b0;
            end
        end
    end

    // Scale each sample: signed sample times unsigned scale, floor shift by 16
    generate
        for (genvar k = 0; k < CHANNELS; k++)
        begin : g_scale
            logic signed [PROD_W-1:0] prod;
            assign prod = $signed(chan_raw_next[k])
                        * $signed({1'b0, scale_reg});
            assign uv_val[k] = prod[eegfd_pkg::UV_SHIFT +: UV_W];
        end
    endgenerate

    // Check the sequence byte and count losses, saturating
    always_comb
    begin
        lost = seen_first_reg && (seq_now_reg != seq_prev_reg + BYTE_W'(1));
        loss_next = loss_reg;
        if (lost && (loss_reg != eegfd_pkg::LOSS_MAX))
        begin
            loss_next = loss_reg + LOSS_W'(1);
        end
    end

    // Advance the decimation counter once per frame
    always_comb
    begin
        keep = (decim_reg == '0);
        decim_inc = {1'b0, decim_reg} + (BYTE_W + 1)'(1);
        if (decim_inc >= {1'b0, decimation_reg})
        begin
            decim_next = '0;
        end
        else
        begin
            decim_next = decim_inc[BYTE_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= eegfd_pkg::SCALE_RESET;
            decimation_reg <= eegfd_pkg::DECIMATION_RESET;
            header_reg     <= eegfd_pkg::HEADER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eegfd_pkg::CFG_SCALE:      scale_reg      <= cfg_data[SCALE_W-1:0];
                eegfd_pkg::CFG_DECIMATION: decimation_reg <= cfg_data[BYTE_W-1:0];
                eegfd_pkg::CFG_HEADER:     header_reg     <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Framing, sequence and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg     <= 1'b0;
            pos_reg        <= '0;
            seq_now_reg    <= '0;
            seq_prev_reg   <= '0;
            seen_first_reg <= 1'b0;
            loss_reg       <= '0;
            decim_reg      <= '0;
        end
        else if (in_fire && active)
        begin
            synced_reg <= 1'b1;
            pos_reg    <= pos_next;
            if (pos_cur == eegfd_pkg::SEQ_POS)
            begin
                seq_now_reg <= rx_byte;
            end
            if (last_byte)
            begin
                seq_prev_reg   <= seq_now_reg;
                seen_first_reg <= 1'b1;
                loss_reg       <= loss_next;
                decim_reg      <= decim_next;
            end
        end
    end

    // Hold the raw samples
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (uv_next[k])
                begin
                    chan_raw_reg[k] <= chan_raw_next[k];
                end
            end
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (frame_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                uv_reg[k] <= uv_val[k];
            end
            keep_reg     <= keep;
            lost_reg     <= lost;
            loss_out_reg <= loss_next;
        end
    end

    // Drive unused channel fields with zero
    generate
        for (genvar k = 0; k < OUT_CH; k++)
        begin : g_port
            if (k < CHANNELS)
            begin : g_used
                assign uv_port[k] = uv_reg[k];
            end
            else
            begin : g_unused
                assign uv_port[k] = '0;
            end
        end
    endgenerate

    assign out_valid     = out_valid_reg;
    assign chan1_uv      = uv_port[0];
    assign chan2_uv      = uv_port[1];
    assign chan3_uv      = uv_port[2];
    assign chan4_uv      = uv_port[3];
    assign chan5_uv      = uv_port[4];
    assign chan6_uv      = uv_port[5];
    assign chan7_uv      = uv_port[6];
    assign chan8_uv      = uv_port[7];
    assign keep_for_plot = keep_reg;
    assign seq_lost      = lost_reg;
    assign loss_total    = loss_out_reg;

endmodule
